### sv/scfla_pkg.sv
// Shared constants and types for the size class allocator.
package scfla_pkg;

   localparam int unsigned ArenaBytes    = 65536;
   localparam int unsigned GrainBytes    = 16;
   localparam int unsigned MaxSmallBytes = 1024;
   localparam int unsigned RefillCount   = 20;

   localparam int unsigned CmdW  = 1;
   localparam int unsigned SizeW = 16;
   localparam int unsigned AddrW = 16;
   localparam int unsigned StatW = 2;

   localparam logic [CmdW-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CmdW-1:0] CMD_FREE  = 1'b1;

   localparam logic [StatW-1:0] STAT_OK    = 2'd0;
   localparam logic [StatW-1:0] STAT_LARGE = 2'd1;
   localparam logic [StatW-1:0] STAT_OOM   = 2'd2;

   typedef struct packed {
      logic [CmdW-1:0]  cmd;
      logic [SizeW-1:0] request_size;
      logic [AddrW-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [AddrW-1:0] granted_address;
      logic [StatW-1:0] status;
   } rsp_type;

endpackage

### sv/scfla_if.sv
// Valid/ready channel interface carrying one payload.
interface scfla_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/scfla_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module scfla_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/size_class_free_list_allocator.sv
// Size class free list allocator: a sequencer over class head and link memories.
// One request is taken at a time; ready is low while it is worked and while its result
// waits to be taken. A free reads the class head, then links the freed block in as the new
// head. A hit on a class list does a head read, a link read and a head writeback. A refill
// from the current pool carves up to REFILL_COUNT blocks and writes one link per cycle into
// the link memory. A nonzero pool remainder is pushed onto its own class list before the
// pool is grown from the arena tail. The fallback scan tries the request's class and then
// larger classes. When the pool is short, the block count k is found by repeated subtract.
// After reset the class head memory is swept to the null marker, one entry a cycle, before
// the first request is taken.
module size_class_free_list_allocator #(
   parameter int unsigned ARENA_BYTES     = scfla_pkg::ArenaBytes,
   parameter int unsigned GRAIN_BYTES     = scfla_pkg::GrainBytes,
   parameter int unsigned MAX_SMALL_BYTES = scfla_pkg::MaxSmallBytes,
   parameter int unsigned REFILL_COUNT    = scfla_pkg::RefillCount
) (
   input logic  clock,
   input logic  reset,
   scfla_if.sink   req,
   scfla_if.source rsp
);
   localparam int unsigned Grains  = ARENA_BYTES / GRAIN_BYTES;
   localparam int unsigned Classes = MAX_SMALL_BYTES / GRAIN_BYTES;
   localparam int unsigned GW      = $clog2(Grains) + 1;   // holds null marker
   localparam int unsigned GI      = $clog2(Grains);
   localparam int unsigned CW      = $clog2(Classes);
   localparam int unsigned SW      = CW + 1;               // class size in grains
   localparam int unsigned KW      = $clog2(REFILL_COUNT + 1);
   localparam int unsigned TW      = $clog2(ARENA_BYTES) + 2;
   localparam int unsigned SH      = $clog2(GRAIN_BYTES);
   localparam int unsigned XW      = GW + 2;
   localparam logic [GW-1:0] NullMark = GW'(Grains);

   typedef enum logic [14:0] {
      S_CLEAR  = 15'b000000000000001,
      S_IDLE   = 15'b000000000000010,
      S_HEAD   = 15'b000000000000100,
      S_HWAIT  = 15'b000000000001000,
      S_POP    = 15'b000000000010000,
      S_LWAIT  = 15'b000000000100000,
      S_CARVE  = 15'b000000001000000,
      S_CDIV   = 15'b000000010000000,
      S_GROW   = 15'b000000100000000,
      S_SCAN   = 15'b000001000000000,
      S_SWAIT  = 15'b000010000000000,
      S_SLINK  = 15'b000100000000000,
      S_LINK   = 15'b001000000000000,
      S_RESP   = 15'b010000000000000,
      S_SDONE  = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   scfla_pkg::req_type req_ff, req_in;
   scfla_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] cls_ff, cls_in;       // request class
   logic [SW-1:0] sz_ff, sz_in;
   logic [CW-1:0] scan_ff, scan_in;     // fallback scan class
   logic [GW-1:0] head_ff, head_in;
   logic [GW-1:0] pool_start_ff, pool_start_in;
   logic [GW-1:0] pool_end_ff, pool_end_in;
   logic [GW-1:0] arena_top_ff, arena_top_in;
   logic [TW-1:0] total_taken_ff, total_taken_in;
   logic [KW-1:0] k_ff, k_in;
   logic [GW-1:0] left_ff, left_in;
   logic [GW-1:0] base_ff, base_in;
   logic [GW-1:0] cur_ff, cur_in;
   logic [KW-1:0] i_ff, i_in;
   logic          regrow_ff, regrow_in; // carve after grow or scan

   // class head memory
   logic          h_we;
   logic [CW-1:0] h_wa, h_ra;
   logic [GW-1:0] h_wd, h_rd;
   // link memory
   logic          l_we;
   logic [GI-1:0] l_wa, l_ra;
   logic [GW-1:0] l_wd, l_rd;

   scfla_ram #(.WIDTH(GW), .DEPTH(Classes)) u_heads (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd)
   );

   scfla_ram #(.WIDTH(GW), .DEPTH(Grains)) u_links (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_addr(l_ra), .rd_data(l_rd)
   );

   logic [GW-1:0] need;
   logic [XW-1:0] extra, get, room;

   always_comb begin
      need  = GW'(sz_ff * REFILL_COUNT);
      extra = XW'(((total_taken_ff >> 4) + TW'(GRAIN_BYTES - 1)) >> SH);
      get   = XW'({need, 1'b0}) + extra;
      room  = XW'(Grains) - XW'(arena_top_ff);
   end

   always_comb begin
      logic [scfla_pkg::SizeW-1:0] sz_bytes;
      logic [GW-1:0]    pleft;
      state_in       = state_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      cls_in         = cls_ff;
      sz_in          = sz_ff;
      scan_in        = scan_ff;
      head_in        = head_ff;
      pool_start_in  = pool_start_ff;
      pool_end_in    = pool_end_ff;
      arena_top_in   = arena_top_ff;
      total_taken_in = total_taken_ff;
      k_in           = k_ff;
      left_in        = left_ff;
      base_in        = base_ff;
      cur_in         = cur_ff;
      i_in           = i_ff;
      regrow_in      = regrow_ff;
      h_we = 1'b0; h_wa = cls_ff; h_wd = NullMark; h_ra = cls_ff;
      l_we = 1'b0; l_wa = cur_ff[GI-1:0]; l_wd = NullMark; l_ra = head_ff[GI-1:0];
      sz_bytes = '0;
      pleft = (pool_end_ff > pool_start_ff) ? pool_end_ff - pool_start_ff : '0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // sweep heads to null marker
            h_we = 1'b1; h_wa = scan_ff; h_wd = NullMark;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == CW'(Classes - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // hold off a new request until the previous result is taken
            if (req.valid && !rsp_valid_ff) begin
               req_in = req.payload;
               rsp_in = '{granted_address: '0, status: scfla_pkg::STAT_OK};
               if (32'(req.payload.request_size) > MAX_SMALL_BYTES) begin
                  rsp_in.status = scfla_pkg::STAT_LARGE;
                  state_in = S_RESP;
               end else begin
                  sz_bytes = (req.payload.request_size == '0)
                                ? (scfla_pkg::SizeW)'(GRAIN_BYTES)
                                : req.payload.request_size;
                  sz_in  = SW'((sz_bytes + (scfla_pkg::SizeW)'(GRAIN_BYTES - 1)) >> SH);
                  cls_in = CW'(sz_in - 1'b1);
                  if (req.payload.cmd == scfla_pkg::CMD_FREE) begin
                     cur_in = GW'(req.payload.block_address >> SH);
                     state_in = (32'(cur_in) < Grains) ? S_HEAD : S_RESP;
                  end else begin
                     state_in = S_HEAD;
                  end
               end
            end
         end
         S_HEAD: begin
            h_ra = cls_ff;
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            head_in = h_rd;
            if (req_ff.cmd == scfla_pkg::CMD_FREE) begin
               // push freed block
               l_we = 1'b1; l_wa = cur_ff[GI-1:0]; l_wd = h_rd;
               h_we = 1'b1; h_wa = cls_ff; h_wd = cur_ff;
               state_in = S_RESP;
            end else if (h_rd >= NullMark) begin
               regrow_in = 1'b0;
               state_in = S_CARVE;
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            l_ra = head_ff[GI-1:0];
            state_in = S_LWAIT;
         end
         S_LWAIT: begin
            h_we = 1'b1; h_wa = cls_ff; h_wd = l_rd;
            rsp_in.granted_address = (scfla_pkg::AddrW)'({head_ff, SH'(0)});
            state_in = S_RESP;
         end
         S_CARVE: begin
            base_in = pool_start_ff;
            if (pleft >= need) begin
               k_in = KW'(REFILL_COUNT);
               pool_start_in = pool_start_ff + need;
               state_in = S_LINK;
               i_in = KW'(1);
               cur_in = pool_start_ff + GW'(sz_ff);
            end else if (pleft >= GW'(sz_ff)) begin
               // count blocks by repeated subtract
               k_in = '0;
               left_in = pleft;
               state_in = S_CDIV;
            end else if (regrow_ff) begin
               pool_start_in = pool_end_ff;
               rsp_in.status = scfla_pkg::STAT_OOM;
               state_in = S_RESP;
            end else begin
               if (pleft != '0) begin
                  // remainder onto its own class list, via head read
                  cls_in = CW'(pleft - 1'b1);
                  h_ra = CW'(pleft - 1'b1);
                  cur_in = pool_start_ff;
                  state_in = S_SLINK;
               end else begin
                  state_in = S_GROW;
               end
               pool_start_in = pool_end_ff;
            end
         end
         S_SLINK: begin
            // head of remainder class is ready now
            l_we = 1'b1; l_wa = cur_ff[GI-1:0]; l_wd = h_rd;
            h_we = 1'b1; h_wa = cls_ff; h_wd = cur_ff;
            cls_in = CW'(sz_ff - 1'b1);
            state_in = S_GROW;
         end
         S_CDIV: begin
            if (left_ff >= GW'(sz_ff)) begin
               left_in = left_ff - GW'(sz_ff);
               k_in = k_ff + 1'b1;
               pool_start_in = pool_start_ff + GW'(sz_ff);
            end else begin
               i_in = KW'(1);
               cur_in = base_ff + GW'(sz_ff);
               state_in = S_LINK;
            end
         end
         S_GROW: begin
            regrow_in = 1'b1;
            if (get <= room) begin
               pool_start_in  = arena_top_ff;
               pool_end_in    = GW'(XW'(arena_top_ff) + get);
               arena_top_in   = GW'(XW'(arena_top_ff) + get);
               total_taken_in = total_taken_ff + TW'({get, SH'(0)});
               state_in = S_CARVE;
            end else begin
               scan_in = CW'(sz_ff - 1'b1);
               h_ra = CW'(sz_ff - 1'b1);
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: begin
            head_in = h_rd;
            if (h_rd < NullMark) begin
               l_ra = h_rd[GI-1:0];
               state_in = S_SDONE;
            end else if (scan_ff == CW'(Classes - 1)) begin
               pool_start_in = pool_end_ff;
               rsp_in.status = scfla_pkg::STAT_OOM;
               state_in = S_RESP;
            end else begin
               scan_in = scan_ff + 1'b1;
               h_ra = scan_ff + 1'b1;
            end
         end
         S_SDONE: begin
            h_we = 1'b1; h_wa = scan_ff; h_wd = l_rd;
            pool_start_in = head_ff;
            pool_end_in = head_ff + GW'(scan_ff) + 1'b1;
            state_in = S_CARVE;
         end
         S_LINK: begin
            rsp_in.granted_address = (scfla_pkg::AddrW)'({base_ff, SH'(0)});
            if (k_ff <= KW'(1)) begin
               state_in = S_RESP;
            end else begin
               if (i_ff == KW'(1)) begin
                  h_we = 1'b1; h_wa = cls_ff; h_wd = cur_ff;
               end
               if (i_ff + 1'b1 < k_ff) begin
                  l_we = 1'b1; l_wa = cur_ff[GI-1:0]; l_wd = cur_ff + GW'(sz_ff);
                  i_in = i_ff + 1'b1;
                  cur_in = cur_ff + GW'(sz_ff);
               end else begin
                  l_we = 1'b1; l_wa = cur_ff[GI-1:0]; l_wd = NullMark;
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         rsp_valid_ff   <= 1'b0;
         scan_ff        <= '0;
         pool_start_ff  <= '0;
         pool_end_ff    <= '0;
         arena_top_ff   <= '0;
         total_taken_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_ff        <= scan_in;
         pool_start_ff  <= pool_start_in;
         pool_end_ff    <= pool_end_in;
         arena_top_ff   <= arena_top_in;
         total_taken_ff <= total_taken_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      cls_ff    <= cls_in;
      sz_ff     <= sz_in;
      head_ff   <= head_in;
      k_ff      <= k_in;
      left_ff   <= left_in;
      base_ff   <= base_in;
      cur_ff    <= cur_in;
      i_ff      <= i_in;
      regrow_ff <= regrow_in;
   end

   assign req.ready   = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
endmodule

### sv/scfla_checker.sv
// Port-level checker for the allocator, bound to the allocator module.
module scfla_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input scfla_pkg::rsp_type  rsp_payload
);
   property p_one_outstanding;
      @(posedge clock) disable iff (reset) rsp_valid |-> !req_ready;
   endproperty
   assert property (p_one_outstanding) else $error("ready while result pending");

   property p_status_code;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_payload.status == scfla_pkg::STAT_OK ||
                        rsp_payload.status == scfla_pkg::STAT_LARGE ||
                        rsp_payload.status == scfla_pkg::STAT_OOM);
   endproperty
   assert property (p_status_code) else $error("bad status");

   property p_zero_on_fail;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_payload.status != scfla_pkg::STAT_OK)
            |-> rsp_payload.granted_address == '0;
   endproperty
   assert property (p_zero_on_fail) else $error("address on failure");

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_payload);
   endproperty
   assert property (p_rsp_hold) else $error("result dropped while stalled");
endmodule

bind size_class_free_list_allocator scfla_checker u_scfla_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
